// File: sv/assert_macros.svh
// Assertion macros shared by the expander RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: sv/ogx_pkg.sv
// Shared types and constants for the outlined glyph expander.
// No dependencies; used by every module of the block.
package ogx_pkg;

  localparam int CellCols    = 12;
  localparam int CellRows    = 18;
  localparam int CellBytes   = 54;
  localparam int BytesPerRow = 3;
  localparam int PixPerByte  = 4;

  // Source glyph and where it lands in the cell
  localparam int SrcRows   = 7;
  localparam int SrcCols   = 5;
  localparam int WhiteRow0 = 5;
  localparam int WhiteCol0 = 3;

  // Outline region: source area grown by one pixel on every side
  localparam int HaloRows = SrcRows + 2;
  localparam int HaloCols = SrcCols + 2;
  localparam int HaloRow0 = WhiteRow0 - 1;
  localparam int HaloCol0 = WhiteCol0 - 1;

  localparam int QueueDepth = 2;

  localparam logic [1:0] PixWhite = 2'h2;
  localparam logic [1:0] PixBlack = 2'h0;
  localparam logic [1:0] PixClear = 2'h1;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] src_row_0;
    logic [7:0] src_row_1;
    logic [7:0] src_row_2;
    logic [7:0] src_row_3;
    logic [7:0] src_row_4;
    logic [7:0] src_row_5;
    logic [7:0] src_row_6;
  } glyph_t;

  typedef struct packed {
    logic [7:0] out_char_code;
    logic [5:0] byte_index;
    logic [7:0] cell_byte;
    logic       last_byte;
  } cell_out_t;

  // Classified glyph: white pixels, column 0 leftmost, and outline coverage
  typedef struct packed {
    logic [7:0]                             code;
    logic [SrcRows-1:0][SrcCols-1:0]        white;
    logic [HaloRows-1:0][HaloCols-1:0]      halo;
  } entry_t;

endpackage

// File: sv/ogx_front.sv
// Front end of the expander: takes a glyph and classifies its pixels.
// Depends on ogx_pkg; feeds ogx_fifo.
module ogx_front (
  input  logic            start_i,
  input  ogx_pkg::glyph_t glyph_i,
  input  logic            full_i,
  output logic            busy_o,
  output logic            push_o,
  output ogx_pkg::entry_t entry_o
);

  logic [ogx_pkg::SrcRows-1:0][7:0] rows;
  logic [ogx_pkg::SrcRows-1:0][ogx_pkg::SrcCols-1:0] white;
  logic [ogx_pkg::HaloRows-1:0][ogx_pkg::HaloCols-1:0] halo;

  assign rows = {glyph_i.src_row_6, glyph_i.src_row_5, glyph_i.src_row_4,
                 glyph_i.src_row_3, glyph_i.src_row_2, glyph_i.src_row_1,
                 glyph_i.src_row_0};

  // Flip column order so that index 0 is the leftmost pixel; upper bits drop
  always_comb begin
    for (int r = 0; r < ogx_pkg::SrcRows; r++) begin
      for (int c = 0; c < ogx_pkg::SrcCols; c++) begin
        white[r][c] = rows[r][ogx_pkg::SrcCols-1-c];
      end
    end
  end

  // Outline coverage: any white pixel within the 3x3 window
  always_comb begin
    int sr;
    int sc;
    for (int k = 0; k < ogx_pkg::HaloRows; k++) begin
      for (int j = 0; j < ogx_pkg::HaloCols; j++) begin
        halo[k][j] = 1'b0;
        for (int dr = 0; dr < 3; dr++) begin
          for (int dc = 0; dc < 3; dc++) begin
            sr = k - 2 + dr;
            sc = j - 2 + dc;
            if (sr >= 0 && sr < ogx_pkg::SrcRows && sc >= 0 && sc < ogx_pkg::SrcCols) begin
              halo[k][j] = halo[k][j] | white[sr][sc];
            end
          end
        end
      end
    end
  end

  assign busy_o        = full_i;
  assign push_o        = start_i & ~full_i;
  assign entry_o.code  = glyph_i.char_code;
  assign entry_o.white = white;
  assign entry_o.halo  = halo;

endmodule

// File: sv/ogx_fifo.sv
// Short queue of classified glyphs between front and back ends.
// Depends on ogx_pkg for the entry type.
module ogx_fifo #(
  parameter int Depth = ogx_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ogx_pkg::entry_t data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output ogx_pkg::entry_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ogx_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/ogx_back.sv
// Back end of the expander: walks the cell and emits one packed byte a cycle.
// Depends on ogx_pkg and assert_macros.svh; drains ogx_fifo.
`include "assert_macros.svh"

module ogx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                qvalid_i,
  input  ogx_pkg::entry_t     qdata_i,
  output logic                pop_o,
  output logic                strobe_o,
  output ogx_pkg::cell_out_t  result_o
);

  ogx_pkg::entry_t    entry_q;
  logic               active_q;
  logic [5:0]         idx_q;
  logic [4:0]         row_q;
  logic [1:0]         grp_q;
  logic               strobe_q;
  ogx_pkg::cell_out_t res_q;

  logic               at_last;
  logic               load;
  logic [4:0]         wofs;
  logic [4:0]         hofs;
  logic [ogx_pkg::CellCols-1:0] wrow;
  logic [ogx_pkg::CellCols-1:0] hrow;
  logic [3:0]         col0;
  logic [ogx_pkg::PixPerByte-1:0] wsel;
  logic [ogx_pkg::PixPerByte-1:0] hsel;
  logic [7:0]         packed_byte;

  assign at_last = (idx_q == 6'(ogx_pkg::CellBytes - 1));
  // Take the next glyph on the last byte so that glyphs run without a gap
  assign load    = qvalid_i && (!active_q || at_last);
  assign pop_o   = load;

  always_comb begin
    wofs = row_q - 5'(ogx_pkg::WhiteRow0);
    hofs = row_q - 5'(ogx_pkg::HaloRow0);
    wrow = '0;
    hrow = '0;
    if (row_q >= 5'(ogx_pkg::WhiteRow0) &&
        row_q <  5'(ogx_pkg::WhiteRow0 + ogx_pkg::SrcRows)) begin
      wrow[ogx_pkg::WhiteCol0 +: ogx_pkg::SrcCols] = entry_q.white[wofs[2:0]];
    end
    if (row_q >= 5'(ogx_pkg::HaloRow0) &&
        row_q <  5'(ogx_pkg::HaloRow0 + ogx_pkg::HaloRows)) begin
      hrow[ogx_pkg::HaloCol0 +: ogx_pkg::HaloCols] = entry_q.halo[hofs[3:0]];
    end
  end

  assign col0 = {grp_q, 2'b00};
  assign wsel = wrow[col0 +: ogx_pkg::PixPerByte];
  assign hsel = hrow[col0 +: ogx_pkg::PixPerByte];

  // Leftmost pixel goes to the top bits
  always_comb begin
    packed_byte = '0;
    for (int p = 0; p < ogx_pkg::PixPerByte; p++) begin
      if (wsel[p]) begin
        packed_byte[(ogx_pkg::PixPerByte-1-p)*2 +: 2] = ogx_pkg::PixWhite;
      end else if (hsel[p]) begin
        packed_byte[(ogx_pkg::PixPerByte-1-p)*2 +: 2] = ogx_pkg::PixBlack;
      end else begin
        packed_byte[(ogx_pkg::PixPerByte-1-p)*2 +: 2] = ogx_pkg::PixClear;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      row_q    <= '0;
      grp_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (load) begin
        active_q <= 1'b1;
        idx_q    <= '0;
        row_q    <= '0;
        grp_q    <= '0;
      end else if (active_q) begin
        if (at_last) begin
          active_q <= 1'b0;
          idx_q    <= '0;
          row_q    <= '0;
          grp_q    <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
          if (grp_q == 2'(ogx_pkg::BytesPerRow - 1)) begin
            grp_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= qdata_i;
    end
    res_q.out_char_code <= entry_q.code;
    res_q.byte_index    <= idx_q;
    res_q.cell_byte     <= packed_byte;
    res_q.last_byte     <= at_last;
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

  `ASSERT_NEXT(a_stream_advances, strobe_q && !res_q.last_byte, strobe_q && (res_q.byte_index == $past(res_q.byte_index) + 6'd1))
  `ASSERT_NEXT(a_glyph_restarts, strobe_q && res_q.last_byte, !strobe_q || (res_q.byte_index == 6'd0))
  `ASSERT_NEXT(a_no_idle_with_work, qvalid_i && !active_q, active_q && (idx_q == 6'd0))

endmodule

// File: sv/outlined_glyph_expander.sv
// Outlined glyph expander: 5x7 glyph in, 12x18 two-bit-per-pixel cell out.
// Input: glyph_i (character code and seven source rows) is transferred at a
//   rising edge where start_i is high and busy_o is low.
// Output: 54 bytes per glyph, one per cycle, each on result_o for exactly one
//   cycle with strobe_o high; byte_index counts 0..53 in row order, three
//   bytes per cell row, and last_byte marks byte 53. Pixels are 2 white,
//   0 black outline, 1 transparent, leftmost pixel in bits 7..6.
// A transferred glyph is written into the queue, loaded into the emitter once the
//   emitter is free, and each of its bytes is registered onto result_o.
// The byte emitter writes one byte a cycle; consecutive glyphs stream with no
//   gap between them when the next glyph is already waiting in the queue.
// A queue of QueueDepth classified glyphs sits between the front end and the
//   emitter; busy_o is high only while that queue is full.
// Reset clears the queue and the emitter; no byte is produced until a glyph
//   is transferred. The receiver cannot stall: every strobed byte is taken.
module outlined_glyph_expander #(
  parameter int QueueDepth = ogx_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  ogx_pkg::glyph_t    glyph_i,
  output logic               strobe_o,
  output ogx_pkg::cell_out_t result_o
);

  logic            push;
  logic            pop;
  logic            qvalid;
  logic            qfull;
  ogx_pkg::entry_t entry_in;
  ogx_pkg::entry_t entry_out;

  ogx_front u_front (
    .start_i (start_i),
    .glyph_i (glyph_i),
    .full_i  (qfull),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (entry_in)
  );

  ogx_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .pop_i   (pop),
    .valid_o (qvalid),
    .full_o  (qfull),
    .data_o  (entry_out)
  );

  ogx_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qvalid_i (qvalid),
    .qdata_i  (entry_out),
    .pop_o    (pop),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule

// File: bench/tb.sv
// Self-checking bench for outlined_glyph_expander: bursts of glyphs go in, every cell byte
// is checked against a cell expanded here from the same glyph.
// Depends on ogx_pkg and the expander RTL only.
module tb;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  ogx_pkg::glyph_t    glyph_i = '0;
  logic               busy_o;
  logic               strobe_o;
  ogx_pkg::cell_out_t result_o;

  ogx_pkg::glyph_t    glyph_queue[$];
  ogx_pkg::cell_out_t cell_bytes_due[$];
  int                 mismatches = 0;
  int                 burst_left = 1;
  int                 gap_left = 0;

  outlined_glyph_expander dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .glyph_i (glyph_i),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // White test on the held glyph; anything off the source area is not white
  function automatic logic is_lit(
    input logic [ogx_pkg::SrcRows-1:0][ogx_pkg::SrcCols-1:0] rows,
    input int col, input int row);
    if (col < ogx_pkg::WhiteCol0 || col >= ogx_pkg::WhiteCol0 + ogx_pkg::SrcCols ||
        row < ogx_pkg::WhiteRow0 || row >= ogx_pkg::WhiteRow0 + ogx_pkg::SrcRows) begin
      return 1'b0;
    end
    return rows[row - ogx_pkg::WhiteRow0][ogx_pkg::SrcCols - 1 - (col - ogx_pkg::WhiteCol0)];
  endfunction

  // Expand one glyph into its 54 cell bytes and queue them in emit order
  function automatic void expand_glyph(input ogx_pkg::glyph_t g);
    logic [ogx_pkg::SrcRows-1:0][ogx_pkg::SrcCols-1:0] rows;
    ogx_pkg::cell_out_t b;
    logic [1:0] pix;
    rows[0] = g.src_row_0[4:0];
    rows[1] = g.src_row_1[4:0];
    rows[2] = g.src_row_2[4:0];
    rows[3] = g.src_row_3[4:0];
    rows[4] = g.src_row_4[4:0];
    rows[5] = g.src_row_5[4:0];
    rows[6] = g.src_row_6[4:0];
    for (int idx = 0; idx < ogx_pkg::CellBytes; idx++) begin
      b.out_char_code = g.char_code;
      b.byte_index    = 6'(idx);
      b.cell_byte     = '0;
      b.last_byte     = (idx == ogx_pkg::CellBytes - 1);
      for (int p = 0; p < ogx_pkg::PixPerByte; p++) begin
        int col;
        int row;
        col = (idx % ogx_pkg::BytesPerRow) * ogx_pkg::PixPerByte + p;
        row = idx / ogx_pkg::BytesPerRow;
        if (is_lit(rows, col, row)) begin
          pix = ogx_pkg::PixWhite;
        end else begin
          pix = ogx_pkg::PixClear;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (is_lit(rows, col + dx, row + dy)) pix = ogx_pkg::PixBlack;
        end
        b.cell_byte[7 - 2*p -: 2] = pix;
      end
      cell_bytes_due.push_back(b);
    end
  endfunction

  // Driver: bursts of glyphs separated by gaps of random length
  always @(posedge clk_i) begin : drive
    bit took;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      took = start_i && !busy_o;
      if (took) begin
        expand_glyph(glyph_i);
        void'(glyph_queue.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                    : $urandom_range(1, 5);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(55, 130);
            default: gap_left = $urandom_range(1, 60);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (glyph_queue.size() != 0) begin
        start_i <= 1'b1;
        glyph_i <= glyph_queue[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobed byte must match the oldest byte still due
  always @(posedge clk_i) begin : watch
    ogx_pkg::cell_out_t want;
    if (rst_ni && strobe_o) begin
      if (cell_bytes_due.size() == 0) begin
        $error("unexpected cell byte: code %0h index %0d byte %0h",
               result_o.out_char_code, result_o.byte_index, result_o.cell_byte);
        mismatches++;
      end else begin
        want = cell_bytes_due.pop_front();
        if (result_o.out_char_code !== want.out_char_code) begin
          $error("out_char_code: expected %0h, got %0h",
                 want.out_char_code, result_o.out_char_code);
          mismatches++;
        end
        if (result_o.byte_index !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, result_o.byte_index);
          mismatches++;
        end
        if (result_o.cell_byte !== want.cell_byte) begin
          $error("cell_byte: expected %0h, got %0h (index %0d)",
                 want.cell_byte, result_o.cell_byte, want.byte_index);
          mismatches++;
        end
        if (result_o.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b (index %0d)",
                 want.last_byte, result_o.last_byte, want.byte_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [7:0]      body;
    logic [7:0]      code;
    ogx_pkg::glyph_t g;
    // Directed glyphs: empty, full, upper bits only, corners, patterns
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h00, 56'h0}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'hFF, {7{8'hFF}}}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h41, {7{8'h1F}}}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h80, {7{8'hE0}}}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h01, 8'h10, 48'h0}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h02, 8'h01, 48'h0}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h03, 48'h0, 8'h10}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'hFE, 48'h0, 8'h01}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h7F, 24'h0, 8'h04, 24'h0}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'hAA, 56'h15_0A_15_0A_15_0A_15}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h55, 56'h0A_15_0A_15_0A_15_0A}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h30, 56'h1F_11_11_11_11_11_1F}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'h41, 56'hEE_B1_D1_FF_31_51_91}));
    glyph_queue.push_back(ogx_pkg::glyph_t'({8'hC3, 56'hE0_00_20_00_40_00_80}));

    // Random glyphs: mostly letter-like density, some sparse, some dense
    repeat (366) begin
      code = 8'($urandom_range(0, 255));
      g = ogx_pkg::glyph_t'({code, 56'h0});
      for (int r = 0; r < ogx_pkg::SrcRows; r++) begin
        case ($urandom_range(0, 3))
          0:       body = 8'($urandom & $urandom);
          1:       body = 8'($urandom | $urandom);
          default: body = 8'($urandom_range(0, 255));
        endcase
        case (r)
          0: g.src_row_0 = body;
          1: g.src_row_1 = body;
          2: g.src_row_2 = body;
          3: g.src_row_3 = body;
          4: g.src_row_4 = body;
          5: g.src_row_5 = body;
          default: g.src_row_6 = body;
        endcase
      end
      glyph_queue.push_back(g);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (glyph_queue.size() != 0 || cell_bytes_due.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
